// ===== rtl/polyphonic_decaying_tone_synth_macros.svh =====
// assertion macros for the tone synth
// no dependencies; taken in by files that carry concurrent checks
`ifndef POLYPHONIC_DECAYING_TONE_SYNTH_MACROS_SVH
`define POLYPHONIC_DECAYING_TONE_SYNTH_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PDTS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define PDTS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PDTS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define PDTS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/pdts_pkg.sv =====
// shared constants, types and tables of the tone synth
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package pdts_pkg;

	localparam int NUM_VOICES       = 13;
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int SAMPLE_WRAP      = 800000;
	localparam int PITCH_COUNT      = 13;

	localparam int VOICE_W    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int IDX_W      = $clog2(SINE_TABLE_DEPTH);
	localparam int PHASE_W    = 32;
	localparam int ENV_W      = 17;
	localparam int GAIN_W     = 31;
	localparam int SINE_W     = 16;
	localparam int KEY_W      = 10;
	localparam int SIDX_W     = 20;
	localparam int SAMPLE_W   = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int PROD1_W    = GAIN_W + ENV_W;
	localparam int PROD2_W    = PROD1_W + 1 + SINE_W;
	localparam int TERM_SHIFT = 31;
	localparam int TERM_W     = 33;
	localparam int SUM_W      = TERM_W + $clog2(NUM_VOICES) + 1;

	localparam logic [ENV_W-1:0]  ENV_FULL    = 17'h10000;
	localparam logic [GAIN_W-1:0] GAIN_RESET  = 31'd165191049;
	localparam logic [ENV_W-1:0]  DECAY_RESET = 17'd26;

	// command codes
	localparam logic CMD_KEY  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_VOICE_GAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP = 2'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} synth_state_t;

	typedef struct packed {
		logic [ENV_W-1:0]   env;
		logic [PHASE_W-1:0] phase;
	} voice_ent_t;

	// phase increments, round(f / 8000 * 2^32), C4 up to C5
	typedef logic [PHASE_W-1:0] pitch_inc_t [PITCH_COUNT];
	localparam pitch_inc_t PITCH_INC = '{
		32'd140459389, 32'd148811490, 32'd157660196, 32'd167035036, 32'd176967685,
		32'd187490355, 32'd198639016, 32'd210450713, 32'd222965174, 32'd236223201,
		32'd250269892, 32'd265151417, 32'd280918242
	};

	typedef logic [KEY_W-1:0] key_map_t [PITCH_COUNT];
	localparam key_map_t KEY_FOR_VOICE = '{
		10'h010, 10'h003, 10'h011, 10'h004, 10'h012, 10'h013, 10'h006,
		10'h014, 10'h007, 10'h015, 10'h008, 10'h016, 10'h017
	};

	typedef logic [PHASE_W-1:0] voice_inc_t [NUM_VOICES];
	typedef logic [KEY_W-1:0]   voice_key_t [NUM_VOICES];

	// voices past the pitch table get no increment
	function automatic voice_inc_t build_voice_inc();
		voice_inc_t t;
		for (int v = 0; v < NUM_VOICES; v++) begin
			t[v] = (v < PITCH_COUNT) ? PITCH_INC[v] : '0;
		end
		return t;
	endfunction

	function automatic voice_key_t build_voice_key();
		voice_key_t t;
		for (int v = 0; v < NUM_VOICES; v++) begin
			t[v] = (v < PITCH_COUNT) ? KEY_FOR_VOICE[v] : '0;
		end
		return t;
	endfunction

	function automatic logic [NUM_VOICES-1:0] build_voice_keyed();
		logic [NUM_VOICES-1:0] m;
		for (int v = 0; v < NUM_VOICES; v++) begin
			m[v] = (v < PITCH_COUNT);
		end
		return m;
	endfunction

	localparam voice_inc_t            VOICE_INC   = build_voice_inc();
	localparam voice_key_t            VOICE_KEY   = build_voice_key();
	localparam logic [NUM_VOICES-1:0] VOICE_KEYED = build_voice_keyed();

	localparam longint Q30 = 64'sd1073741824;

	// one sine rom entry: q30 horner quarter-wave polynomial, q1.15 result
	function automatic logic signed [SINE_W-1:0] sine_entry(input int k);
		longint four;
		longint quad;
		longint rem;
		longint x;
		longint x2;
		longint acc;
		longint r;
		four = longint'(k) * 4;
		quad = four / SINE_TABLE_DEPTH;
		rem  = four - quad * SINE_TABLE_DEPTH;
		x    = (rem * Q30) / SINE_TABLE_DEPTH;
		if (quad[0]) begin
			x = Q30 - x;
		end
		x2  = (x * x) / Q30;
		acc = 64'sd172272;
		acc = -64'sd5026996 + (acc * x2) / Q30;
		acc = 64'sd85569305 + (acc * x2) / Q30;
		acc = -64'sd693598342 + (acc * x2) / Q30;
		acc = 64'sd1686629713 + (acc * x2) / Q30;
		r   = (acc * x) / Q30;
		if (r < 0) begin
			r = 0;
		end
		r = (r * 32767 + (Q30 / 2)) / Q30;
		if (r > 32767) begin
			r = 32767;
		end
		if (quad[1]) begin
			r = -r;
		end
		return SINE_W'(r);
	endfunction

	typedef logic signed [SINE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t t;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			t[k] = sine_entry(k);
		end
		return t;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// ===== rtl/pdts_if.sv =====
// valid/ready channels of the tone synth: note/tick input, sample output, config writes
// depends on pdts_pkg for field widths
`default_nettype none

interface pdts_in_if;
	logic                       valid;
	logic                       ready;
	logic                       command;
	logic [pdts_pkg::KEY_W-1:0] key_code;
	logic                       pressed;

	modport source (output valid, output command, output key_code, output pressed,
		input ready);
	modport sink (input valid, input command, input key_code, input pressed,
		output ready);
endinterface

interface pdts_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [pdts_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface pdts_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [pdts_pkg::CFG_IDX_W-1:0]  index;
	logic [pdts_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/polyphonic_decaying_tone_synth.sv =====
// thirteen-voice sine synth with linear release decay, top level
// depends on pdts_pkg, the pdts channel interfaces and the assertion macro header
`default_nettype none
`include "polyphonic_decaying_tone_synth_macros.svh"

// A key event (command 0) sets or clears the held flag of the voice its key code maps to
// and gives no output. A sample tick (command 1) gives one signed sample: the voices are
// walked one per cycle through the read port of the voice state memory (envelope and
// phase), and each voice's term then passes a six-stage chain of rom lookup, two
// multiplies, truncation and accumulation before the sample is saturated into the
// output register. The next item is taken once the sample is in that register, even
// if it has not been taken yet. Config writes are always ready and take effect at once.
module polyphonic_decaying_tone_synth (
	input  wire              clk,
	input  wire              arst_n,
	pdts_cfg_if.sink         cfg,
	pdts_in_if.sink          note_in,
	pdts_out_if.source       sample_out
);

	localparam logic [pdts_pkg::VOICE_W-1:0] LAST_VOICE =
		pdts_pkg::VOICE_W'(pdts_pkg::NUM_VOICES - 1);
	localparam logic [pdts_pkg::IDX_W:0] DEPTH_K =
		(pdts_pkg::IDX_W + 1)'(pdts_pkg::SINE_TABLE_DEPTH);
	localparam logic [pdts_pkg::PROD2_W-1:0] TRUNC_BIAS =
		pdts_pkg::PROD2_W'((64'd1 << pdts_pkg::TERM_SHIFT) - 64'd1);
	localparam logic signed [pdts_pkg::SUM_W-1:0] SUM_MAX =
		{{(pdts_pkg::SUM_W - pdts_pkg::SAMPLE_W + 1){1'b0}},
		 {(pdts_pkg::SAMPLE_W - 1){1'b1}}};
	localparam logic signed [pdts_pkg::SUM_W-1:0] SUM_MIN =
		{{(pdts_pkg::SUM_W - pdts_pkg::SAMPLE_W + 1){1'b1}},
		 {(pdts_pkg::SAMPLE_W - 1){1'b0}}};

	pdts_pkg::synth_state_t state_q, state_d;

	logic [pdts_pkg::GAIN_W-1:0]     gain_q;
	logic [pdts_pkg::ENV_W-1:0]      decay_q;
	logic [pdts_pkg::NUM_VOICES-1:0] note_held_q;
	logic [pdts_pkg::NUM_VOICES-1:0] ent_valid_q;
	logic [pdts_pkg::SIDX_W-1:0]     sample_index_q;
	logic                            wrap_q;
	logic [pdts_pkg::VOICE_W-1:0]    voice_q;

	logic in_ready_c;
	logic issue_c;
	logic out_load_c;
	logic in_acc;
	logic tick_acc;
	logic key_acc;

	// voice state memory
	pdts_pkg::voice_ent_t voice_mem [pdts_pkg::NUM_VOICES];

	// stage registers
	logic                             vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [pdts_pkg::VOICE_W-1:0]     voice_s1;
	logic                             held_s1;
	logic                             ent_vld_s1;
	pdts_pkg::voice_ent_t             rd_ent_s1;
	logic [pdts_pkg::PHASE_W-1:0]     phase_s2;
	logic [pdts_pkg::ENV_W-1:0]       env_s2;
	logic [pdts_pkg::IDX_W-1:0]       idx_s3;
	logic [pdts_pkg::PROD1_W-1:0]     prod1_s3, prod1_s4;
	logic signed [pdts_pkg::SINE_W-1:0]  sine_s4;
	logic signed [pdts_pkg::PROD2_W-1:0] prod2_s5;
	logic signed [pdts_pkg::TERM_W-1:0]  term_s6;
	logic signed [pdts_pkg::SUM_W-1:0]   sum_q;

	logic                            out_valid_q;
	logic signed [pdts_pkg::SAMPLE_W-1:0] sample_q;

	logic [pdts_pkg::SIDX_W-1:0]          sidx_inc;
	logic                                 sidx_wrap;
	logic [pdts_pkg::PHASE_W-1:0]         phase_cur, phase_new;
	logic [pdts_pkg::ENV_W-1:0]           env_cur, env_eff, env_new;
	pdts_pkg::voice_ent_t                 wr_ent;
	logic [pdts_pkg::PHASE_W+pdts_pkg::IDX_W:0] rom_pos;
	logic signed [pdts_pkg::PROD2_W-1:0]  biased;
	logic signed [pdts_pkg::SAMPLE_W-1:0] sat_sample;

	assign cfg.ready          = 1'b1;
	assign note_in.ready      = in_ready_c;
	assign sample_out.valid   = out_valid_q;
	assign sample_out.sample  = sample_q;

	assign in_acc   = note_in.valid && in_ready_c;
	assign tick_acc = in_acc && (note_in.command == pdts_pkg::CMD_TICK);
	assign key_acc  = in_acc && (note_in.command == pdts_pkg::CMD_KEY);

	// control

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready_c = 1'b0;
		issue_c    = 1'b0;
		out_load_c = 1'b0;
		unique case (state_q)
			pdts_pkg::ST_IDLE: begin
				in_ready_c = 1'b1;
				if (note_in.valid && note_in.command == pdts_pkg::CMD_TICK) begin
					state_d = pdts_pkg::ST_SCAN;
				end
			end
			pdts_pkg::ST_SCAN: begin
				issue_c = 1'b1;
				if (voice_q == LAST_VOICE) begin
					state_d = pdts_pkg::ST_DRAIN;
				end
			end
			pdts_pkg::ST_DRAIN: begin
				if (!(vld_s1 || vld_s2 || vld_s3 || vld_s4 || vld_s5 || vld_s6)) begin
					state_d = pdts_pkg::ST_EMIT;
				end
			end
			pdts_pkg::ST_EMIT: begin
				if (!out_valid_q || sample_out.ready) begin
					out_load_c = 1'b1;
					state_d    = pdts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pdts_pkg::ST_IDLE;
			end
		endcase
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= pdts_pkg::GAIN_RESET;
			decay_q <= pdts_pkg::DECAY_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				pdts_pkg::CFG_VOICE_GAIN: gain_q  <= cfg.data[pdts_pkg::GAIN_W-1:0];
				pdts_pkg::CFG_DECAY_STEP: decay_q <= cfg.data[pdts_pkg::ENV_W-1:0];
				default: ;
			endcase
		end
	end

	assign sidx_inc  = sample_index_q + 1'b1;
	assign sidx_wrap = (sidx_inc >= pdts_pkg::SIDX_W'(pdts_pkg::SAMPLE_WRAP));

	// key map, sample counter, voice walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_held_q    <= '0;
			sample_index_q <= '0;
			wrap_q         <= 1'b0;
			voice_q        <= '0;
		end else begin
			if (key_acc) begin
				for (int v = 0; v < pdts_pkg::NUM_VOICES; v++) begin
					if (pdts_pkg::VOICE_KEYED[v] && note_in.key_code == pdts_pkg::VOICE_KEY[v]) begin
						note_held_q[v] <= note_in.pressed;
					end
				end
			end
			if (tick_acc) begin
				sample_index_q <= sidx_wrap ? '0 : sidx_inc;
				wrap_q         <= sidx_wrap;
				voice_q        <= '0;
			end else if (issue_c) begin
				voice_q <= voice_q + 1'b1;
			end
		end
	end

	// valid chain and entry-written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			ent_valid_q <= '0;
		end else begin
			vld_s1 <= issue_c;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			if (vld_s1) begin
				ent_valid_q[voice_s1] <= 1'b1;
			end
		end
	end

	// memory read port, registered
	always_ff @(posedge clk) begin
		if (issue_c) begin
			rd_ent_s1 <= voice_mem[voice_q];
		end
	end

	// memory write port; each voice is touched once per tick and the
	// walk starts only after the previous one has drained
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			voice_mem[voice_s1] <= wr_ent;
		end
	end

	// stage 1: phase advance, envelope force and decay
	always_comb begin
		phase_cur = ent_vld_s1 ? rd_ent_s1.phase : '0;
		env_cur   = ent_vld_s1 ? rd_ent_s1.env : '0;
		phase_new = wrap_q ? '0 : phase_cur + pdts_pkg::VOICE_INC[voice_s1];
		env_eff   = held_s1 ? pdts_pkg::ENV_FULL : env_cur;
		env_new   = (env_eff > decay_q) ? env_eff - decay_q : '0;
		wr_ent.env   = env_new;
		wr_ent.phase = phase_new;
	end

	// rom position: (phase * depth) >> 32
	assign rom_pos = {{(pdts_pkg::IDX_W + 1){1'b0}}, phase_s2}
		* {{pdts_pkg::PHASE_W{1'b0}}, DEPTH_K};

	// truncate toward zero on the shift
	assign biased = prod2_s5 + (prod2_s5[pdts_pkg::PROD2_W-1] ? TRUNC_BIAS : '0);

	always_ff @(posedge clk) begin
		voice_s1   <= voice_q;
		held_s1    <= note_held_q[voice_q];
		ent_vld_s1 <= ent_valid_q[voice_q];
		phase_s2   <= phase_new;
		env_s2     <= env_eff;
		idx_s3     <= rom_pos[pdts_pkg::PHASE_W +: pdts_pkg::IDX_W];
		prod1_s3   <= pdts_pkg::PROD1_W'(gain_q) * pdts_pkg::PROD1_W'(env_s2);
		sine_s4    <= pdts_pkg::SINE_ROM[idx_s3];
		prod1_s4   <= prod1_s3;
		prod2_s5   <= pdts_pkg::PROD2_W'($signed({1'b0, prod1_s4}))
			* pdts_pkg::PROD2_W'(sine_s4);
		term_s6    <= pdts_pkg::TERM_W'(biased >>> pdts_pkg::TERM_SHIFT);
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			sum_q <= '0;
		end else if (vld_s6) begin
			sum_q <= sum_q + pdts_pkg::SUM_W'(term_s6);
		end
	end

	always_comb begin
		if (sum_q > SUM_MAX) begin
			sat_sample = SUM_MAX[pdts_pkg::SAMPLE_W-1:0];
		end else if (sum_q < SUM_MIN) begin
			sat_sample = SUM_MIN[pdts_pkg::SAMPLE_W-1:0];
		end else begin
			sat_sample = sum_q[pdts_pkg::SAMPLE_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load_c) begin
			out_valid_q <= 1'b1;
		end else if (sample_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load_c) begin
			sample_q <= sat_sample;
		end
	end

	`PDTS_ASSERT_IMP(a_idle_pipe_empty, clk, arst_n, state_q == pdts_pkg::ST_IDLE, !(vld_s1 || vld_s2 || vld_s3 || vld_s4 || vld_s5 || vld_s6), "voice pipeline busy while idle")
	`PDTS_ASSERT_IMP(a_sample_from_emit, clk, arst_n, $rose(out_valid_q), $past(state_q) == pdts_pkg::ST_EMIT, "sample appeared outside emit")
	`PDTS_ASSERT_NXT(a_tick_starts_walk, clk, arst_n, tick_acc, state_q == pdts_pkg::ST_SCAN && voice_q == '0, "tick did not start voice walk at voice zero")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// testbench of the tone synth: note and tick items, directed then random, checked sample by sample
// depends on pdts_pkg, the pdts channel interfaces and the polyphonic_decaying_tone_synth top level
module tb;
	import pdts_pkg::*;

	localparam int     WATCHDOG_CYCLES = 3000;
	localparam int     SETTLE_CYCLES   = 40;
	localparam int     LONG_HOLD       = 400;
	localparam longint Q30_ONE         = 64'sd1073741824;
	localparam logic [ENV_W-1:0]  FULL_ENV       = 17'h10000;
	localparam logic [GAIN_W-1:0] GAIN_AT_RESET  = 31'd165191049;
	localparam logic [ENV_W-1:0]  DECAY_AT_RESET = 17'd26;
	// indexes past the register list, writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	typedef struct packed {
		logic             command;
		logic [KEY_W-1:0] key_code;
		logic             pressed;
	} note_item_t;

	logic clk;
	logic arst_n;

	pdts_cfg_if cfg ();
	pdts_in_if  note_in ();
	pdts_out_if sample_out ();

	polyphonic_decaying_tone_synth DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.note_in   (note_in),
		.sample_out(sample_out)
	);

	// synth state as the testbench sees it
	logic [GAIN_W-1:0]  gain_reg;
	logic [ENV_W-1:0]   decay_reg;
	logic               held [NUM_VOICES];
	logic [ENV_W-1:0]   env_level [NUM_VOICES];
	logic [PHASE_W-1:0] phase_acc [NUM_VOICES];
	logic [SIDX_W-1:0]  tick_count;

	note_item_t                 pending [$];
	logic signed [SAMPLE_W-1:0] samples_due [$];
	note_item_t                 launch;
	logic signed [SAMPLE_W-1:0] want;

	int errors;
	int idle_cycles;
	int src_gap;
	int sink_gap;
	int holds_asked;
	int holds_given;
	bit calm;

	function automatic logic [PHASE_W-1:0] pitch_step(input int v);
		case (v)
			0:  return 32'd140459389;
			1:  return 32'd148811490;
			2:  return 32'd157660196;
			3:  return 32'd167035036;
			4:  return 32'd176967685;
			5:  return 32'd187490355;
			6:  return 32'd198639016;
			7:  return 32'd210450713;
			8:  return 32'd222965174;
			9:  return 32'd236223201;
			10: return 32'd250269892;
			11: return 32'd265151417;
			12: return 32'd280918242;
			default: return '0;
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] key_of_voice(input int v);
		case (v)
			0:  return 10'h010;
			1:  return 10'h003;
			2:  return 10'h011;
			3:  return 10'h004;
			4:  return 10'h012;
			5:  return 10'h013;
			6:  return 10'h006;
			7:  return 10'h014;
			8:  return 10'h007;
			9:  return 10'h015;
			10: return 10'h008;
			11: return 10'h016;
			12: return 10'h017;
			default: return '0;
		endcase
	endfunction

	// q1.15 sine of the rom slot that a phase selects, quarter-wave polynomial in q30
	function automatic longint sine_q15(input logic [PHASE_W-1:0] ph);
		longint slot;
		longint quadrant;
		longint offset;
		longint x;
		longint x2;
		longint acc;
		longint mag;
		slot     = (longint'(ph) * SINE_TABLE_DEPTH) >> 32;
		quadrant = (slot * 4) / SINE_TABLE_DEPTH;
		offset   = slot * 4 - quadrant * SINE_TABLE_DEPTH;
		x        = (offset * Q30_ONE) / SINE_TABLE_DEPTH;
		if (quadrant[0]) begin
			x = Q30_ONE - x;
		end
		x2  = (x * x) / Q30_ONE;
		acc = 64'sd172272;
		acc = -64'sd5026996 + (acc * x2) / Q30_ONE;
		acc = 64'sd85569305 + (acc * x2) / Q30_ONE;
		acc = -64'sd693598342 + (acc * x2) / Q30_ONE;
		acc = 64'sd1686629713 + (acc * x2) / Q30_ONE;
		mag = (acc * x) / Q30_ONE;
		if (mag < 0) begin
			mag = 0;
		end
		mag = (mag * 32767 + Q30_ONE / 2) / Q30_ONE;
		if (mag > 32767) begin
			mag = 32767;
		end
		return quadrant[1] ? -mag : mag;
	endfunction

	// one sample tick: step phases, mix all voices, then decay
	function automatic logic signed [SAMPLE_W-1:0] mix_tick();
		longint sum;
		longint term;
		sum = 0;
		tick_count = tick_count + 1'b1;
		if (tick_count >= SAMPLE_WRAP) begin
			tick_count = '0;
			for (int v = 0; v < NUM_VOICES; v++) begin
				phase_acc[v] = '0;
			end
		end else begin
			for (int v = 0; v < NUM_VOICES; v++) begin
				phase_acc[v] = phase_acc[v] + pitch_step(v);
			end
		end
		for (int v = 0; v < NUM_VOICES; v++) begin
			if (held[v]) begin
				env_level[v] = FULL_ENV;
			end
			term = longint'(gain_reg) * longint'(env_level[v]) * sine_q15(phase_acc[v]);
			sum += term / 64'sd2147483648;
			env_level[v] = (env_level[v] > decay_reg) ? env_level[v] - decay_reg : '0;
		end
		if (sum > 64'sd2147483647) begin
			sum = 64'sd2147483647;
		end
		if (sum < -64'sd2147483648) begin
			sum = -64'sd2147483648;
		end
		return SAMPLE_W'(sum);
	endfunction

	task automatic apply_note(input note_item_t it);
		if (it.command == CMD_TICK) begin
			samples_due.push_back(mix_tick());
		end else begin
			// unmapped codes match no voice
			for (int v = 0; v < NUM_VOICES; v++) begin
				if (v < PITCH_COUNT && key_of_voice(v) == it.key_code) begin
					held[v] = it.pressed;
				end
			end
		end
	endtask

	task automatic add_key(input logic [KEY_W-1:0] code, input logic down);
		pending.push_back({CMD_KEY, code, down});
	endtask

	task automatic add_tick();
		pending.push_back({CMD_TICK, 10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1))});
	endtask

	// mostly ticks and mapped keys, some unmapped codes as noise
	task automatic add_random(input int count);
		note_item_t it;
		repeat (count) begin
			it.pressed  = 1'($urandom_range(0, 1));
			it.key_code = 10'($urandom_range(0, 1023));
			if ($urandom_range(0, 99) < 55) begin
				it.command = CMD_TICK;
			end else begin
				it.command = CMD_KEY;
				if ($urandom_range(0, 9) < 8) begin
					it.key_code = key_of_voice(int'($urandom_range(0, PITCH_COUNT - 1)));
				end
			end
			pending.push_back(it);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			CFG_VOICE_GAIN: gain_reg = value[GAIN_W-1:0];
			CFG_DECAY_STEP: decay_reg = value[ENV_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained(input bit pause);
		while (pending.size() != 0 || note_in.valid || samples_due.size() != 0) begin
			@(posedge clk);
		end
		if (pause) begin
			repeat (SETTLE_CYCLES) @(posedge clk);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// item driver
	always @(posedge clk) begin
		if (!arst_n) begin
			note_in.valid <= 1'b0;
			src_gap       <= 0;
		end else begin
			if (note_in.valid && note_in.ready) begin
				apply_note({note_in.command, note_in.key_code, note_in.pressed});
			end
			if (!note_in.valid || note_in.ready) begin
				if (src_gap > 0) begin
					src_gap       <= src_gap - 1;
					note_in.valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 15) == 0) begin
					src_gap       <= int'($urandom_range(0, 10));
					note_in.valid <= 1'b0;
				end else if (pending.size() != 0) begin
					launch = pending.pop_front();
					note_in.command  <= launch.command;
					note_in.key_code <= launch.key_code;
					note_in.pressed  <= launch.pressed;
					note_in.valid    <= 1'b1;
				end else begin
					note_in.valid <= 1'b0;
				end
			end
		end
	end

	// sample receiver with random stalls and the occasional long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			sample_out.ready <= 1'b0;
			sink_gap         <= 0;
			holds_given      <= 0;
		end else if (holds_given != holds_asked) begin
			holds_given      <= holds_given + 1;
			sink_gap         <= LONG_HOLD;
			sample_out.ready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap         <= sink_gap - 1;
			sample_out.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			sink_gap         <= int'($urandom_range(0, 10));
			sample_out.ready <= 1'b0;
		end else begin
			sample_out.ready <= 1'b1;
		end
	end

	// sample monitor
	always @(posedge clk) begin
		if (arst_n && sample_out.valid && sample_out.ready) begin
			if (samples_due.size() == 0) begin
				$error("sample: none expected, got %0d", sample_out.sample);
				errors++;
			end else begin
				want = samples_due.pop_front();
				if (sample_out.sample !== want) begin
					$error("sample: expected %0d, got %0d", want, sample_out.sample);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake anywhere
	always @(posedge clk) begin
		if (!arst_n || (note_in.valid && note_in.ready) || (sample_out.valid && sample_out.ready)
				|| (cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("[polyphonic_decaying_tone_synth] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n           = 1'b0;
		cfg.valid        = 1'b0;
		cfg.index        = CFG_VOICE_GAIN;
		cfg.data         = '0;
		note_in.valid    = 1'b0;
		note_in.command  = CMD_KEY;
		note_in.key_code = '0;
		note_in.pressed  = 1'b0;
		sample_out.ready = 1'b0;
		errors           = 0;
		idle_cycles      = 0;
		src_gap          = 0;
		sink_gap         = 0;
		holds_asked      = 0;
		holds_given      = 0;
		calm             = 1'b0;
		gain_reg         = GAIN_AT_RESET;
		decay_reg        = DECAY_AT_RESET;
		tick_count       = '0;
		for (int v = 0; v < NUM_VOICES; v++) begin
			held[v]      = 1'b0;
			env_level[v] = '0;
			phase_acc[v] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// silence, unmapped codes, two voices held then released into the slow decay
		add_tick();
		add_key(10'h000, 1'b1);
		add_key(10'h3FF, 1'b1);
		add_key(10'h155, 1'b0);
		add_key(10'h2AA, 1'b1);
		add_tick();
		add_key(10'h010, 1'b1);
		add_tick();
		add_tick();
		add_key(10'h017, 1'b1);
		add_tick();
		add_key(10'h010, 1'b0);
		add_key(10'h017, 1'b0);
		add_tick();
		add_tick();
		wait_drained(1'b1);

		// full gain drives the mix into saturation; decay of full scale kills a voice in one tick
		write_reg(CFG_VOICE_GAIN, 32'hFFFF_FFFF);
		write_reg(CFG_DECAY_STEP, 32'hFFFE_0000 | 32'd65536);
		add_key(10'h003, 1'b1);
		add_key(10'h011, 1'b1);
		add_key(10'h004, 1'b1);
		add_key(10'h012, 1'b1);
		add_tick();
		add_tick();
		add_tick();
		add_key(10'h003, 1'b0);
		add_tick();
		add_random(280);
		wait_drained(1'b1);

		// zero gain, no decay; sender waits for the last sample halfway
		write_reg(CFG_VOICE_GAIN, 32'd0);
		write_reg(CFG_DECAY_STEP, 32'd0);
		add_random(80);
		wait_drained(1'b0);
		add_random(80);
		wait_drained(1'b1);

		// decay step past full scale
		write_reg(CFG_VOICE_GAIN, $urandom);
		write_reg(CFG_DECAY_STEP, 32'd131071);
		add_random(160);
		wait_drained(1'b1);

		// spare indexes are ignored; long output stall fills the block
		write_reg(CFG_SPARE_A, $urandom);
		write_reg(CFG_SPARE_B, $urandom);
		write_reg(CFG_DECAY_STEP, 32'd1);
		write_reg(CFG_VOICE_GAIN, 32'h7FFF_FFFF);
		add_random(280);
		holds_asked++;
		wait_drained(1'b1);

		write_reg(CFG_VOICE_GAIN, $urandom);
		write_reg(CFG_DECAY_STEP, $urandom_range(0, 65536));
		add_random(270);
		wait_drained(1'b1);

		// last stretch runs without stalls
		write_reg(CFG_VOICE_GAIN, 32'd165191049);
		write_reg(CFG_DECAY_STEP, 32'd2000);
		calm = 1'b1;
		add_random(290);
		wait_drained(1'b1);

		if (errors == 0) begin
			$display("[polyphonic_decaying_tone_synth] OK");
		end else begin
			$display("[polyphonic_decaying_tone_synth] ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pdts_pkg.sv
rtl/pdts_if.sv
rtl/polyphonic_decaying_tone_synth.sv
dv/tb.sv
